[design/prb_pkg.sv]
// Shared constants, register codes and the quarter-wave sine table of the polar resampler.
package prb_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X   = 3'd0,
		CFG_CENTER_Y   = 3'd1,
		CFG_ANG_POINTS = 3'd2,
		CFG_RAD_POINTS = 3'd3,
		CFG_IMG_WIDTH  = 3'd4,
		CFG_IMG_HEIGHT = 3'd5
	} cfg_idx_t;

	// Quotient bits resolved in each divider stage.
	localparam int DIV_BPS = 4;
	// Bits of radius_index times max_radius.
	localparam int RAD_PROD_W = 21;
	// Width of the angle quotient, which stays below 4096 * 360.
	localparam int ANG_Q_W = 21;

	localparam int FULL_TURN = 360;
	localparam int HALF_TURN = 180;
	localparam int QUARTER   = 90;

	// floor(q / 360) is (q * RECIP_360) >> RECIP_SHIFT for every q below 2^21.
	localparam logic [21:0] RECIP_360   = 22'd2982617;
	localparam int          RECIP_SHIFT = 30;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam int TRIG_W = 17;

	typedef logic [QUARTER:0][TRIG_W-1:0] sin_tab_t;

	// Taylor series of the sine in Q30, rounded to Q16; evaluated at elaboration only.
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    tab;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		int          d;
		int          k;
		for (d = 0; d <= QUARTER; d++) begin
			x    = (64'(d) * PI_Q30) / 64'(HALF_TURN);
			term = x;
			sum  = x;
			for (k = 1; k <= 6; k++) begin
				term = (((term * x) >> 30) * x) >> 30;
				case (k)
					1: term = term / 64'd6;
					2: term = term / 64'd20;
					3: term = term / 64'd42;
					4: term = term / 64'd72;
					5: term = term / 64'd110;
					default: term = term / 64'd156;
				endcase
				if ((k % 2) == 1) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			sum = (sum + 64'd8192) >> 14;
			if (sum > 64'd65536) begin
				sum = 64'd65536;
			end
			tab[d] = sum[TRIG_W-1:0];
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

[design/prb_div_pipe.sv]
// Pipelined restoring divider that resolves a few quotient bits in each stage.
module prb_div_pipe #(
	parameter int N   = 37,
	parameter int D   = 13,
	parameter int BPS = 4
) (
	input  logic         clk,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient
);

	localparam int STG = (N + BPS - 1) / BPS;
	localparam int NP  = STG * BPS;

	logic [STG-1:0][D-1:0]  rem_q;
	logic [STG-1:0][NP-1:0] dvd_q;
	logic [STG-1:0][NP-1:0] quo_q;
	logic [STG-1:0][D-1:0]  dsr_q;

	logic [STG-1:0][D-1:0]  src_rem;
	logic [STG-1:0][NP-1:0] src_dvd;
	logic [STG-1:0][NP-1:0] src_quo;
	logic [STG-1:0][D-1:0]  src_dsr;

	logic [STG-1:0][D-1:0]  nxt_rem;
	logic [STG-1:0][NP-1:0] nxt_dvd;
	logic [STG-1:0][NP-1:0] nxt_quo;

	always_comb begin
		logic [D:0]    trial;
		logic [D-1:0]  rem;
		logic [NP-1:0] dvd;
		logic [NP-1:0] quo;
		src_rem[0] = '0;
		src_dvd[0] = NP'(dividend);
		src_quo[0] = '0;
		src_dsr[0] = divisor;
		for (int s = 1; s < STG; s++) begin
			src_rem[s] = rem_q[s-1];
			src_dvd[s] = dvd_q[s-1];
			src_quo[s] = quo_q[s-1];
			src_dsr[s] = dsr_q[s-1];
		end
		for (int s = 0; s < STG; s++) begin
			rem = src_rem[s];
			dvd = src_dvd[s];
			quo = src_quo[s];
			for (int b = 0; b < BPS; b++) begin
				trial = {rem, dvd[NP-1]};
				dvd   = {dvd[NP-2:0], 1'b0};
				if (trial >= {1'b0, src_dsr[s]}) begin
					trial = trial - {1'b0, src_dsr[s]};
					quo   = {quo[NP-2:0], 1'b1};
				end else begin
					quo   = {quo[NP-2:0], 1'b0};
				end
				rem = trial[D-1:0];
			end
			nxt_rem[s] = rem;
			nxt_dvd[s] = dvd;
			nxt_quo[s] = quo;
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < STG; s++) begin
			rem_q[s] <= nxt_rem[s];
			dvd_q[s] <= nxt_dvd[s];
			quo_q[s] <= nxt_quo[s];
			dsr_q[s] <= src_dsr[s];
		end
	end

	assign quotient = quo_q[STG-1][N-1:0];

endmodule

[design/prb_image_mem.sv]
// Image store split into four banks by row and column parity, one read per bank per cycle.
module prb_image_mem #(
	parameter int AW = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [1:0]           wbank,
	input  logic [AW-1:0]        waddr,
	input  logic [31:0]          wdata,
	input  logic [3:0][AW-1:0]   raddr,
	output logic [3:0][31:0]     rdata
);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [31:0] mem [0:(2**AW)-1];

		always_ff @(posedge clk) begin
			if (we && (wbank == 2'(b))) begin
				mem[waddr] <= wdata;
			end
			rdata[b] <= mem[raddr[b]];
		end
	end

endmodule

[design/polar_resample_bilinear_unit.sv]
// Top level of the polar resampler: configuration, angle and radius pipeline, bilinear fetch.
//
// Channel   Direction  Handshake               Payload
// request   in         start, busy             op, column, row, pixel_value,
//                                               radius_index, angle_index
// config    in         cfg_we                  cfg_idx, cfg_data
// result    out        result_valid (strobe)   sample_value, neighbor_clipped
//
// One request is taken every cycle; busy stays low.
// A sample passes the request register, the radius and angle dividers and stages 2 to 9;
// the pipelined dividers for radius and angle make up most of that path.
// Pixel writes reach the image banks at the same stage as sample reads, so order is kept.
// Reset clears valid bits, presets the configuration; the image is undefined until written.
module polar_resample_bilinear_unit #(
	parameter int IMG_W     = 512,
	parameter int IMG_H     = 512,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            op,
	input  logic [8:0]                      column,
	input  logic [8:0]                      row,
	input  logic signed [31:0]              pixel_value,
	input  logic [11:0]                     radius_index,
	input  logic [11:0]                     angle_index,
	input  logic                            cfg_we,
	input  logic [prb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [prb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            result_valid,
	output logic signed [47:0]              sample_value,
	output logic                            neighbor_clipped
);

	localparam int RW  = prb_pkg::RAD_PROD_W + FRAC_BITS;
	localparam int OW  = RW + 1;
	localparam int PW  = RW + 2;
	localparam int IW  = PW - FRAC_BITS;
	localparam int STG = (RW + prb_pkg::DIV_BPS - 1) / prb_pkg::DIV_BPS;
	localparam int XB  = (IMG_W > 2) ? $clog2(IMG_W) : 2;
	localparam int YB  = (IMG_H > 2) ? $clog2(IMG_H) : 2;
	localparam int AW  = (XB - 1) + (YB - 1);
	localparam int TW  = prb_pkg::TRIG_W;

	localparam logic [12:0] IMG_W_L = 13'(IMG_W);
	localparam logic [12:0] IMG_H_L = 13'(IMG_H);

	typedef struct packed {
		logic        op;
		logic [8:0]  col;
		logic [8:0]  row;
		logic [31:0] pix;
		logic        clip;
	} side_t;

	typedef struct packed {
		logic       neg;
		logic [6:0] idx;
	} trig_sel_t;

	function automatic trig_sel_t fold_deg(input logic [8:0] d);
		trig_sel_t  s;
		logic [8:0] rem;
		logic       odd;
		if (d >= 9'(3 * prb_pkg::QUARTER)) begin
			rem = d - 9'(3 * prb_pkg::QUARTER);
			odd = 1'b1;
			s.neg = 1'b1;
		end else if (d >= 9'(2 * prb_pkg::QUARTER)) begin
			rem = d - 9'(2 * prb_pkg::QUARTER);
			odd = 1'b0;
			s.neg = 1'b1;
		end else if (d >= 9'(prb_pkg::QUARTER)) begin
			rem = d - 9'(prb_pkg::QUARTER);
			odd = 1'b1;
			s.neg = 1'b0;
		end else begin
			rem = d;
			odd = 1'b0;
			s.neg = 1'b0;
		end
		s.idx = odd ? (7'(prb_pkg::QUARTER) - rem[6:0]) : rem[6:0];
		return s;
	endfunction

	// Configuration registers
	logic [8:0]  cx_q;
	logic [8:0]  cy_q;
	logic [12:0] ap_q;
	logic [12:0] rp_q;
	logic [9:0]  iw_q;
	logic [9:0]  ih_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= 9'd256;
			cy_q <= 9'd256;
			ap_q <= 13'd360;
			rp_q <= 13'd500;
			iw_q <= 10'd512;
			ih_q <= 10'd512;
		end else if (cfg_we) begin
			case (cfg_idx)
				prb_pkg::CFG_CENTER_X:   cx_q <= cfg_data[8:0];
				prb_pkg::CFG_CENTER_Y:   cy_q <= cfg_data[8:0];
				prb_pkg::CFG_ANG_POINTS: ap_q <= cfg_data;
				prb_pkg::CFG_RAD_POINTS: rp_q <= cfg_data;
				prb_pkg::CFG_IMG_WIDTH:  iw_q <= cfg_data[9:0];
				prb_pkg::CFG_IMG_HEIGHT: ih_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	logic [12:0] used_w;
	logic [12:0] used_h;
	logic [12:0] dxr;
	logic [12:0] dyt;
	logic [8:0]  max_radius;
	logic [12:0] ap_eff;
	logic [12:0] rp_eff;

	always_comb begin
		logic [12:0] m;
		used_w = ({3'b0, iw_q} > IMG_W_L) ? IMG_W_L : {3'b0, iw_q};
		used_h = ({3'b0, ih_q} > IMG_H_L) ? IMG_H_L : {3'b0, ih_q};
		dxr = (used_w > {4'b0, cx_q}) ? used_w - {4'b0, cx_q} : 13'd0;
		dyt = (used_h > {4'b0, cy_q}) ? used_h - {4'b0, cy_q} : 13'd0;
		m = {4'b0, cx_q};
		if (dxr < m) begin
			m = dxr;
		end
		if ({4'b0, cy_q} < m) begin
			m = {4'b0, cy_q};
		end
		if (dyt < m) begin
			m = dyt;
		end
		max_radius = m[8:0];
		ap_eff = (ap_q == 13'd0) ? 13'd1 : ap_q;
		rp_eff = (rp_q == 13'd0) ? 13'd1 : rp_q;
	end

	logic take;
	assign busy = 1'b0;
	assign take = start & ~busy;

	// Stage 1: registered request
	logic               v_s1;
	logic               op_s1;
	logic [8:0]         col_s1;
	logic [8:0]         row_s1;
	logic [31:0]        pix_s1;
	logic [11:0]        ri_s1;
	logic [11:0]        ai_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= op;
		col_s1 <= column;
		row_s1 <= row;
		pix_s1 <= pixel_value;
		ri_s1  <= radius_index;
		ai_s1  <= angle_index;
	end

	logic [20:0]   rad_prod;
	logic [20:0]   ang_prod;
	logic [RW-1:0] dvd_rad;
	logic [RW-1:0] dvd_ang;
	logic [RW-1:0] q_rad;
	logic [RW-1:0] q_ang;
	side_t         side_in;

	always_comb begin
		rad_prod = 21'(ri_s1) * 21'(max_radius);
		ang_prod = 21'(ai_s1) * 21'(prb_pkg::FULL_TURN);
		dvd_rad  = {rad_prod, {FRAC_BITS{1'b0}}};
		dvd_ang  = RW'(ang_prod);
		side_in.op   = op_s1;
		side_in.col  = col_s1;
		side_in.row  = row_s1;
		side_in.pix  = pix_s1;
		side_in.clip = ({1'b0, ri_s1} >= rp_eff) || ({1'b0, ai_s1} >= ap_eff);
	end

	prb_div_pipe #(.N(RW), .D(13), .BPS(prb_pkg::DIV_BPS)) u_div_rad (
		.clk      (clk),
		.dividend (dvd_rad),
		.divisor  (rp_eff),
		.quotient (q_rad)
	);

	prb_div_pipe #(.N(RW), .D(13), .BPS(prb_pkg::DIV_BPS)) u_div_ang (
		.clk      (clk),
		.dividend (dvd_ang),
		.divisor  (ap_eff),
		.quotient (q_ang)
	);

	// Side data travels alongside the divider stages.
	logic [STG-1:0] sv_q;
	side_t          sd_q [STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= '0;
		end else begin
			sv_q <= {sv_q[STG-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		sd_q[0] <= side_in;
		for (int s = 1; s < STG; s++) begin
			sd_q[s] <= sd_q[s-1];
		end
	end

	// Stage 2: reciprocal product for the degree wrap
	logic          v_s2;
	side_t         sd_s2;
	logic [RW-1:0] r_s2;
	logic [20:0]   qa_s2;
	logic [42:0]   pm_s2;

	// Stage 3: folded sine and cosine angles
	logic          v_s3;
	side_t         sd_s3;
	logic [RW-1:0] r_s3;
	trig_sel_t     ss_s3;
	trig_sel_t     sc_s3;

	// Stage 4: table values
	logic          v_s4;
	side_t         sd_s4;
	logic [RW-1:0] r_s4;
	logic [TW-1:0] ms_s4;
	logic [TW-1:0] mc_s4;
	logic          ns_s4;
	logic          nc_s4;

	// Stage 5: offset magnitudes
	logic          v_s5;
	side_t         sd_s5;
	logic [OW-1:0] ox_s5;
	logic [OW-1:0] oy_s5;
	logic          nx_s5;
	logic          ny_s5;

	// Stage 6: integer positions and weights
	logic                 v_s6;
	side_t                sd_s6;
	logic signed [IW-1:0] x1_s6;
	logic signed [IW-1:0] y1_s6;
	logic [15:0]          wx_s6;
	logic [15:0]          wy_s6;

	// Stage 7: image read
	logic        v_s7;
	logic        op_s7;
	logic        clip_s7;
	logic [3:0]  ncl_s7;
	logic [15:0] wx_s7;
	logic [15:0] wy_s7;
	logic        lx_s7;
	logic        ly_s7;

	// Stage 8: row blends
	logic               v_s8;
	logic               clip_s8;
	logic [15:0]        wy_s8;
	logic signed [50:0] top_s8;
	logic signed [50:0] bot_s8;

	// Stage 9: result
	logic               v_s9;
	logic               clip_s9;
	logic signed [47:0] val_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s2 <= sv_q[STG-1];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7 & op_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage 2
	always_ff @(posedge clk) begin
		sd_s2 <= sd_q[STG-1];
		r_s2  <= q_rad;
		qa_s2 <= q_ang[20:0];
		pm_s2 <= 43'(q_ang[20:0]) * 43'(prb_pkg::RECIP_360);
	end

	// Stage 3
	logic [12:0] turns;
	logic [20:0] deg_full;
	logic [8:0]  deg;
	logic [9:0]  cdeg_raw;
	logic [8:0]  cdeg;

	always_comb begin
		turns    = pm_s2[42:prb_pkg::RECIP_SHIFT];
		deg_full = qa_s2 - 21'(turns) * 21'(prb_pkg::FULL_TURN);
		deg      = deg_full[8:0];
		cdeg_raw = {1'b0, deg} + 10'(prb_pkg::QUARTER);
		if (cdeg_raw >= 10'(prb_pkg::FULL_TURN)) begin
			cdeg = 9'(cdeg_raw - 10'(prb_pkg::FULL_TURN));
		end else begin
			cdeg = cdeg_raw[8:0];
		end
	end

	always_ff @(posedge clk) begin
		sd_s3 <= sd_s2;
		r_s3  <= r_s2;
		ss_s3 <= fold_deg(deg);
		sc_s3 <= fold_deg(cdeg);
	end

	// Stage 4
	always_ff @(posedge clk) begin
		sd_s4 <= sd_s3;
		r_s4  <= r_s3;
		ms_s4 <= prb_pkg::SIN_TAB[ss_s3.idx];
		mc_s4 <= prb_pkg::SIN_TAB[sc_s3.idx];
		ns_s4 <= ss_s3.neg;
		nc_s4 <= sc_s3.neg;
	end

	// Stage 5: the column follows the sine, the row the cosine.
	logic [RW+TW-1:0] prod_x;
	logic [RW+TW-1:0] prod_y;

	always_comb begin
		prod_x = (RW+TW)'(r_s4) * (RW+TW)'(ms_s4);
		prod_y = (RW+TW)'(r_s4) * (RW+TW)'(mc_s4);
	end

	always_ff @(posedge clk) begin
		sd_s5 <= sd_s4;
		ox_s5 <= prod_x[RW+TW-1:16];
		oy_s5 <= prod_y[RW+TW-1:16];
		nx_s5 <= ns_s4;
		ny_s5 <= nc_s4;
	end

	// Stage 6
	logic [PW-1:0] cxp;
	logic [PW-1:0] cyp;
	logic [PW-1:0] px;
	logic [PW-1:0] py;
	logic [15:0]   wx;
	logic [15:0]   wy;

	always_comb begin
		cxp = PW'({cx_q, {FRAC_BITS{1'b0}}});
		cyp = PW'({cy_q, {FRAC_BITS{1'b0}}});
		px  = nx_s5 ? cxp - PW'(ox_s5) : cxp + PW'(ox_s5);
		py  = ny_s5 ? cyp - PW'(oy_s5) : cyp + PW'(oy_s5);
	end

	if (FRAC_BITS >= 16) begin : g_wt_narrow
		assign wx = px[FRAC_BITS-1 -: 16];
		assign wy = py[FRAC_BITS-1 -: 16];
	end else begin : g_wt_wide
		assign wx = {px[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
		assign wy = {py[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
	end

	always_ff @(posedge clk) begin
		sd_s6 <= sd_s5;
		x1_s6 <= $signed(px[PW-1:FRAC_BITS]);
		y1_s6 <= $signed(py[PW-1:FRAC_BITS]);
		wx_s6 <= wx;
		wy_s6 <= wy;
	end

	// Stage 7: clipping, bank addresses and pixel writes
	logic signed [IW-1:0] wl;
	logic signed [IW-1:0] hl;
	logic signed [IW-1:0] xa;
	logic signed [IW-1:0] ya;
	logic                 cx0;
	logic                 cx1;
	logic                 cy0;
	logic                 cy1;
	logic [3:0]           ncl;
	logic [3:0][AW-1:0]   raddr;
	logic [3:0][31:0]     rdata;
	logic                 mem_we;
	logic [XB-1:0]        wcol;
	logic [YB-1:0]        wrow;
	logic [AW-1:0]        waddr;

	always_comb begin
		logic [1:0]           bsel;
		logic signed [IW-1:0] xs;
		logic signed [IW-1:0] ys;
		wl  = $signed(IW'(used_w));
		hl  = $signed(IW'(used_h));
		xa  = x1_s6 + IW'(1);
		ya  = y1_s6 + IW'(1);
		cx0 = (x1_s6 < IW'(0)) || (x1_s6 >= wl);
		cx1 = (x1_s6 < -IW'(1)) || (x1_s6 >= wl - IW'(1));
		cy0 = (y1_s6 < IW'(0)) || (y1_s6 >= hl);
		cy1 = (y1_s6 < -IW'(1)) || (y1_s6 >= hl - IW'(1));
		ncl = {cx1 | cy1, cx0 | cy1, cx1 | cy0, cx0 | cy0};
		for (int b = 0; b < 4; b++) begin
			bsel = 2'(b);
			xs = (x1_s6[0] == bsel[0]) ? x1_s6 : xa;
			ys = (y1_s6[0] == bsel[1]) ? y1_s6 : ya;
			raddr[b] = {ys[YB-1:1], xs[XB-1:1]};
		end
		wcol   = XB'(sd_s6.col);
		wrow   = YB'(sd_s6.row);
		waddr  = {wrow[YB-1:1], wcol[XB-1:1]};
		mem_we = v_s6 && !sd_s6.op && ({4'b0, sd_s6.col} < IMG_W_L)
			&& ({4'b0, sd_s6.row} < IMG_H_L);
	end

	prb_image_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.wbank ({wrow[0], wcol[0]}),
		.waddr (waddr),
		.wdata (sd_s6.pix),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		op_s7   <= sd_s6.op;
		clip_s7 <= sd_s6.clip | (|ncl);
		ncl_s7  <= ncl;
		wx_s7   <= wx_s6;
		wy_s7   <= wy_s6;
		lx_s7   <= x1_s6[0];
		ly_s7   <= y1_s6[0];
	end

	// Stage 8: neighbours outside the image read as zero.
	logic signed [3:0][31:0] nbr;
	logic [16:0]             wxn;
	logic signed [49:0]      p00;
	logic signed [49:0]      p01;
	logic signed [49:0]      p10;
	logic signed [49:0]      p11;

	always_comb begin
		logic [1:0] n;
		for (int k = 0; k < 4; k++) begin
			n = 2'(k);
			nbr[k] = ncl_s7[k] ? 32'd0 : rdata[{ly_s7 ^ n[1], lx_s7 ^ n[0]}];
		end
		wxn = 17'h10000 - {1'b0, wx_s7};
		p00 = $signed(nbr[0]) * $signed({1'b0, wxn});
		p01 = $signed(nbr[1]) * $signed({2'b0, wx_s7});
		p10 = $signed(nbr[2]) * $signed({1'b0, wxn});
		p11 = $signed(nbr[3]) * $signed({2'b0, wx_s7});
	end

	always_ff @(posedge clk) begin
		clip_s8 <= clip_s7;
		wy_s8   <= wy_s7;
		top_s8  <= 51'(p00) + 51'(p01);
		bot_s8  <= 51'(p10) + 51'(p11);
	end

	// Stage 9
	logic [16:0]        wyn;
	logic signed [68:0] q_top;
	logic signed [68:0] q_bot;
	logic signed [69:0] blend;

	always_comb begin
		wyn   = 17'h10000 - {1'b0, wy_s8};
		q_top = top_s8 * $signed({1'b0, wyn});
		q_bot = bot_s8 * $signed({2'b0, wy_s8});
		blend = 70'(q_top) + 70'(q_bot);
	end

	always_ff @(posedge clk) begin
		clip_s9 <= clip_s8;
		val_s9  <= blend[63:16];
	end

	assign result_valid     = v_s9;
	assign sample_value     = val_s9;
	assign neighbor_clipped = clip_s9;

endmodule

[design/prb_checker.sv]
// Port-level checks of request-to-result timing for the polar resampler, bound to the top level.
module prb_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic op,
	input logic result_valid
);

	localparam int LAT = (prb_pkg::RAD_PROD_W + FRAC_BITS + prb_pkg::DIV_BPS - 1)
		/ prb_pkg::DIV_BPS + 9;

	// Every sample transfer yields a result a fixed time later.
	a_sample_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op) |-> ##LAT result_valid)
		else $error("sample request produced no result");

	// A pixel write never yields a result.
	a_write_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !op) |-> ##LAT !result_valid)
		else $error("pixel write produced a result");

	// No result without a matching sample transfer.
	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && op, LAT))
		else $error("result without a sample request");

	// The pipeline never holds a request off.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("request held off");

endmodule

bind polar_resample_bilinear_unit prb_checker #(.FRAC_BITS(FRAC_BITS)) u_prb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.result_valid (result_valid)
);
